>>> hdl/cdsc_pkg.sv
package cdsc_pkg;

  localparam int unsigned YEAR_SPAN_DEF = 256;
  localparam int unsigned BASE_RESET    = 1900;
  localparam int unsigned YW            = 15;   // years up to 16383 + max span
  localparam int unsigned DW            = 24;   // absolute day numbers
  localparam logic [16:0] SERIAL_MAX    = 17'h1FFFF;
  // 2^32 / 365.2425, used for the first year estimate.
  localparam logic [23:0] YEAR_RECIP    = 24'd11759221;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_SPAN    = 2'd2
  } status_e;

  typedef enum logic {
    REG_BASE_YEAR = 1'b0
  } reg_idx_e;

  typedef struct packed {
    logic [16:0]   serial;
    logic [DW-1:0] dbase;
    logic [16:0]   off;
    logic          invalid;
  } fwd_t;

  typedef struct packed {
    logic [16:0]   serial;
    logic [2:0]    wd;
    logic [YW-1:0] oy;
    logic [8:0]    rem;
    logic          leap;
    logic          invalid;
    logic          span_err;
  } bk_t;

  // floor(x / 100), exact for every 15-bit x.
  function automatic logic [YW-1:0] q100(input logic [YW-1:0] x);
    logic [27:0] p;
    p = 28'(x) * 28'd5243;
    return YW'(p >> 19);
  endfunction

  function automatic logic is_leap(input logic [YW-1:0] y);
    logic [YW-1:0] c;
    logic [21:0]   c100;
    logic          cent;
    c    = q100(y);
    c100 = 22'(c) * 22'd100;
    cent = (22'(y) == c100);
    return (y[1:0] == 2'b00) && (!cent || (c[1:0] == 2'b00));
  endfunction

  // Days from January 1 of year 0 to January 1 of year y.
  function automatic logic [DW-1:0] days_before(input logic [YW-1:0] y);
    logic [DW-1:0] lp;
    lp = DW'((y + YW'(3)) >> 2) - DW'(q100(y + YW'(99)))
       + DW'(q100((y + YW'(399)) >> 2));
    return DW'(y) * DW'(365) + lp;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    unique case (m)
      4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
      4'd2:                    r = leap ? 5'd29 : 5'd28;
      default:                 r = 5'd31;
    endcase
    return r;
  endfunction

  // Days of the year that lie before the first of month m.
  function automatic logic [8:0] cum_days(input logic [3:0] m, input logic leap);
    logic [8:0] r;
    unique case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    if (leap && (m > 4'd2)) begin
      r = r + 9'd1;
    end
    return r;
  endfunction

  // Since 8 = 1 mod 7, the octal digits are summed and folded.
  function automatic logic [2:0] mod7(input logic [16:0] s);
    logic [17:0] w;
    logic [5:0]  acc;
    logic [3:0]  f1;
    logic [3:0]  f2;
    w   = {1'b0, s};
    acc = '0;
    for (int k = 0; k < 6; k++) begin
      acc = acc + 6'(w[3*k +: 3]);
    end
    f1 = 4'(acc[2:0]) + 4'(acc[5:3]);
    f2 = 4'(f1[2:0]) + 4'(f1[3]);
    if (f2 >= 4'd7) begin
      f2 = f2 - 4'd7;
    end
    return f2[2:0];
  endfunction

endpackage

>>> hdl/calendar_date_serial_converter_top.sv
// Gregorian date converter. An input transaction carries year, month, day and a
// day offset; each one yields exactly one output transaction with the zero-based
// day count from January 1 of base_year, its weekday (that count mod 7), the date that
// lies the offset later, and a status (ok, invalid date, shifted date out of span).
// Both channels use valid/stall; a transaction moves when valid is high and stall
// is low. The datapath is a six-stage pipeline, and one transaction can enter every
// cycle while stall_o is low. The stages are set by the year-start arithmetic
// (constant multiplies for the leap-year counts) and the reciprocal year estimate.
// When the receiver stalls, the output stage holds and the stages behind it fill
// their empty slots; stall_o rises only once every stage holds a transaction.
// Reset empties the pipeline and sets base_year to 1900. base_year sits at APB address 0;
// the user must write it only while the pipeline is empty; the block itself does not enforce it.
module calendar_date_serial_converter_top import cdsc_pkg::*; #(
  parameter int unsigned YEAR_SPAN = YEAR_SPAN_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [13:0] in_year_i,
  input  logic [3:0]  in_month_i,
  input  logic [4:0]  in_day_i,
  input  logic [16:0] offset_days_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [16:0] serial_day_o,
  output logic [2:0]  weekday_o,
  output logic [13:0] out_year_o,
  output logic [3:0]  out_month_o,
  output logic [4:0]  out_day_o,
  output logic [1:0]  status_o
);

  localparam int unsigned NST = 6;

  logic [13:0]    base_q;
  logic [NST:1]   v_q;
  logic [NST:1]   en;
  logic           in_mv;
  fwd_t           fwd;
  bk_t            bk;
  reg_idx_e       ridx;

  assign ridx   = reg_idx_e'(paddr[2]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= 14'(BASE_RESET);
    end else if (psel && penable && pwrite && (ridx == REG_BASE_YEAR)) begin
      base_q <= pwdata[13:0];
    end
  end

  always_comb begin
    unique case (ridx)
      REG_BASE_YEAR: prdata = 32'(base_q);
      default:       prdata = '0;
    endcase
  end

  // A stage moves when it is empty or the stage ahead of it moves.
  always_comb begin
    en[NST] = !v_q[NST] || !stall_i;
    for (int k = NST - 1; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign stall_o = !en[1];
  assign in_mv   = valid_i && en[1];
  assign valid_o = v_q[NST];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) begin
        v_q[1] <= valid_i;
      end
      for (int k = 2; k <= NST; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  cdsc_front #(.YEAR_SPAN(YEAR_SPAN)) u_front (
    .clk_i        (clk_i),
    .en1_i        (in_mv),
    .en2_i        (en[2]),
    .base_i       (base_q),
    .in_year_i    (in_year_i),
    .in_month_i   (in_month_i),
    .in_day_i     (in_day_i),
    .offset_days_i(offset_days_i),
    .fwd_o        (fwd)
  );

  cdsc_back #(.YEAR_SPAN(YEAR_SPAN)) u_back (
    .clk_i (clk_i),
    .en3_i (en[3]),
    .en4_i (en[4]),
    .en5_i (en[5]),
    .base_i(base_q),
    .fwd_i (fwd),
    .bk_o  (bk)
  );

  cdsc_out u_out (
    .clk_i       (clk_i),
    .en6_i       (en[6]),
    .bk_i        (bk),
    .serial_day_o(serial_day_o),
    .weekday_o   (weekday_o),
    .out_year_o  (out_year_o),
    .out_month_o (out_month_o),
    .out_day_o   (out_day_o),
    .status_o    (status_o)
  );

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (v_q == '1))
    else $error("input stalled while the pipeline has an empty stage");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> (valid_o && $stable(serial_day_o) && $stable(status_o)))
    else $error("stalled result changed");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (status_o == ST_INVALID)) |-> ((serial_day_o == '0) && (out_year_o == '0)))
    else $error("invalid result carries nonzero fields");

  a_ok_month: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (status_o == ST_OK)) |-> ((out_month_o >= 4'd1) && (out_month_o <= 4'd12)
      && (out_day_o >= 5'd1) && (weekday_o < 3'd7)))
    else $error("ok result carries an impossible date");

endmodule

>>> hdl/cdsc_front.sv
module cdsc_front import cdsc_pkg::*; #(
  parameter int unsigned YEAR_SPAN = YEAR_SPAN_DEF
) (
  input  logic        clk_i,
  input  logic        en1_i,
  input  logic        en2_i,
  input  logic [13:0] base_i,
  input  logic [13:0] in_year_i,
  input  logic [3:0]  in_month_i,
  input  logic [4:0]  in_day_i,
  input  logic [16:0] offset_days_i,
  output fwd_t        fwd_o
);

  logic [DW-1:0] dy_q, dy_d, db_q, db_d;
  logic [3:0]    m_q;
  logic [4:0]    d_q;
  logic [16:0]   off_q;
  logic          leap_q, leap_d, bad_q, bad_d;
  logic [YW-1:0] yv, bv, endy;
  logic [21:0]   serial_w;
  fwd_t          fwd_q, fwd_d;

  assign yv     = YW'(in_year_i);
  assign bv     = YW'(base_i);
  assign endy   = bv + YW'(YEAR_SPAN);
  assign dy_d   = days_before(yv);
  assign db_d   = days_before(bv);
  assign leap_d = is_leap(yv);

  always_comb begin
    bad_d = (in_month_i < 4'd1) || (in_month_i > 4'd12) || (in_day_i < 5'd1) ||
            (in_day_i > month_len(in_month_i, leap_d)) || (yv < bv) || (yv >= endy);
  end

  always_ff @(posedge clk_i) begin
    if (en1_i) begin
      dy_q   <= dy_d;
      db_q   <= db_d;
      m_q    <= in_month_i;
      d_q    <= in_day_i;
      off_q  <= offset_days_i;
      leap_q <= leap_d;
      bad_q  <= bad_d;
    end
  end

  always_comb begin
    serial_w       = 22'(dy_q - db_q) + 22'(cum_days(m_q, leap_q)) + 22'(d_q) - 22'd1;
    fwd_d.serial   = serial_w[16:0];
    fwd_d.dbase    = db_q;
    fwd_d.off      = off_q;
    fwd_d.invalid  = bad_q || (serial_w > 22'(SERIAL_MAX));
  end

  always_ff @(posedge clk_i) begin
    if (en2_i) begin
      fwd_q <= fwd_d;
    end
  end

  assign fwd_o = fwd_q;

endmodule

>>> hdl/cdsc_back.sv
module cdsc_back import cdsc_pkg::*; #(
  parameter int unsigned YEAR_SPAN = YEAR_SPAN_DEF
) (
  input  logic        clk_i,
  input  logic        en3_i,
  input  logic        en4_i,
  input  logic        en5_i,
  input  logic [13:0] base_i,
  input  fwd_t        fwd_i,
  output bk_t         bk_o
);

  // Stage 3: absolute day number and a year estimate within one year.
  logic [DW-1:0] a3_q, a3_d;
  logic [47:0]   prod;
  logic [YW-1:0] c3_q, c3_d;
  logic [16:0]   s3_q, s4_q;
  logic [2:0]    w3_q, w4_q;
  logic          i3_q, i4_q;

  assign a3_d = fwd_i.dbase + DW'(fwd_i.serial) + DW'(fwd_i.off);
  assign prod = 48'(a3_d) * 48'(YEAR_RECIP);
  assign c3_d = YW'(prod >> 32);

  always_ff @(posedge clk_i) begin
    if (en3_i) begin
      a3_q <= a3_d;
      c3_q <= c3_d;
      s3_q <= fwd_i.serial;
      w3_q <= mod7(fwd_i.serial);
      i3_q <= fwd_i.invalid;
    end
  end

  // Stage 4: year starts around the estimate.
  logic [DW-1:0] a4_q, dc_q, dc1_q;
  logic [YW-1:0] c4_q;
  logic          lm_q, l0_q, lp_q;

  always_ff @(posedge clk_i) begin
    if (en4_i) begin
      a4_q  <= a3_q;
      c4_q  <= c3_q;
      dc_q  <= days_before(c3_q);
      dc1_q <= days_before(c3_q + YW'(1));
      lm_q  <= is_leap(c3_q - YW'(1));
      l0_q  <= is_leap(c3_q);
      lp_q  <= is_leap(c3_q + YW'(1));
      s4_q  <= s3_q;
      w4_q  <= w3_q;
      i4_q  <= i3_q;
    end
  end

  // Stage 5: pick the year that holds the day, and the day within it.
  logic [YW-1:0] endy;
  bk_t           bk_q, bk_d;
  logic [DW-1:0] remw;

  assign endy = YW'(base_i) + YW'(YEAR_SPAN);

  always_comb begin
    bk_d         = '0;
    bk_d.serial  = s4_q;
    bk_d.wd      = w4_q;
    bk_d.invalid = i4_q;
    priority if (a4_q < dc_q) begin
      bk_d.oy   = c4_q - YW'(1);
      remw      = a4_q - dc_q + (lm_q ? DW'(366) : DW'(365));
      bk_d.leap = lm_q;
    end else if (a4_q >= dc1_q) begin
      bk_d.oy   = c4_q + YW'(1);
      remw      = a4_q - dc1_q;
      bk_d.leap = lp_q;
    end else begin
      bk_d.oy   = c4_q;
      remw      = a4_q - dc_q;
      bk_d.leap = l0_q;
    end
    bk_d.rem      = remw[8:0];
    bk_d.span_err = (bk_d.oy >= endy) || bk_d.oy[YW-1];
  end

  always_ff @(posedge clk_i) begin
    if (en5_i) begin
      bk_q <= bk_d;
    end
  end

  assign bk_o = bk_q;

endmodule

>>> hdl/cdsc_out.sv
module cdsc_out import cdsc_pkg::*; (
  input  logic        clk_i,
  input  logic        en6_i,
  input  bk_t         bk_i,
  output logic [16:0] serial_day_o,
  output logic [2:0]  weekday_o,
  output logic [13:0] out_year_o,
  output logic [3:0]  out_month_o,
  output logic [4:0]  out_day_o,
  output logic [1:0]  status_o
);

  logic [16:0] serial_q;
  logic [2:0]  wd_q;
  logic [13:0] year_q;
  logic [3:0]  month_q, om;
  logic [4:0]  day_q;
  status_e     status_q;
  logic [8:0]  dm;

  // Each month start is compared in parallel; the count of passed starts is the month.
  always_comb begin
    om = 4'd1;
    for (int k = 2; k <= 12; k++) begin
      if (bk_i.rem >= cum_days(4'(k), bk_i.leap)) begin
        om = 4'(k);
      end
    end
    dm = bk_i.rem - cum_days(om, bk_i.leap) + 9'd1;
  end

  always_ff @(posedge clk_i) begin
    if (en6_i) begin
      if (bk_i.invalid) begin
        serial_q <= '0;
        wd_q     <= '0;
        year_q   <= '0;
        month_q  <= '0;
        day_q    <= '0;
        status_q <= ST_INVALID;
      end else if (bk_i.span_err) begin
        serial_q <= bk_i.serial;
        wd_q     <= bk_i.wd;
        year_q   <= '0;
        month_q  <= '0;
        day_q    <= '0;
        status_q <= ST_SPAN;
      end else begin
        serial_q <= bk_i.serial;
        wd_q     <= bk_i.wd;
        year_q   <= bk_i.oy[13:0];
        month_q  <= om;
        day_q    <= dm[4:0];
        status_q <= ST_OK;
      end
    end
  end

  assign serial_day_o = serial_q;
  assign weekday_o    = wd_q;
  assign out_year_o   = year_q;
  assign out_month_o  = month_q;
  assign out_day_o    = day_q;
  assign status_o     = status_q;

endmodule

>>> dv/tb_calendar_date_serial_converter_top.sv
module tb_calendar_date_serial_converter_top;
  import cdsc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SPAN = YEAR_SPAN_DEF;
  localparam int unsigned LAT = 6;

  typedef struct packed {
    logic [16:0] serial;
    logic [2:0]  wd;
    logic [13:0] yr;
    logic [3:0]  mo;
    logic [4:0]  dy;
    status_e     st;
  } date_res_t;

  typedef struct packed {
    logic [13:0] yr;
    logic [3:0]  mo;
    logic [4:0]  dy;
    logic [16:0] off;
    bit          chk;
    date_res_t   want;
  } dir_row_t;

  logic        clk_i, rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        valid_i, stall_o, valid_o, stall_i;
  logic [13:0] in_year_i, out_year_o;
  logic [3:0]  in_month_i, out_month_o;
  logic [4:0]  in_day_i, out_day_o;
  logic [16:0] offset_days_i, serial_day_o;
  logic [2:0]  weekday_o;
  logic [1:0]  status_o;

  calendar_date_serial_converter_top u_dut (.*);

  int unsigned base_yr;
  date_res_t   pending_dates[$];
  int unsigned mismatches, n_sent, n_checked;
  bit          quiet, long_hold;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit leap_year(int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
    case (m)
      4, 6, 9, 11: return 30;
      2:           return leap_year(y) ? 29 : 28;
      default:     return 31;
    endcase
  endfunction

  function automatic date_res_t convert_date(int unsigned y, int unsigned m,
                                              int unsigned d, int unsigned off);
    date_res_t   r;
    int unsigned end_y, ser, tot, oy, om;
    r     = '0;
    r.st  = ST_OK;
    end_y = base_yr + SPAN;
    ser   = 0;
    if (m < 1 || m > 12 || d < 1 || d > days_in_month(m, y) || y < base_yr || y >= end_y) begin
      r.st = ST_INVALID;
      return r;
    end
    for (int unsigned i = base_yr; i < y; i++) ser += leap_year(i) ? 366 : 365;
    for (int unsigned i = 1; i < m; i++) ser += days_in_month(i, y);
    ser += d - 1;
    if (ser > 131071) begin
      r.st = ST_INVALID;
      return r;
    end
    r.serial = 17'(ser);
    r.wd     = 3'(ser % 7);
    tot      = ser + off;
    oy       = base_yr;
    while (oy < end_y && tot >= (leap_year(oy) ? 366 : 365)) begin
      tot -= leap_year(oy) ? 366 : 365;
      oy++;
    end
    if (oy >= end_y || oy > 16383) begin
      r.st = ST_SPAN;
      return r;
    end
    om = 1;
    while (om < 12 && tot >= days_in_month(om, oy)) begin
      tot -= days_in_month(om, oy);
      om++;
    end
    r.yr = 14'(oy);
    r.mo = 4'(om);
    r.dy = 5'((tot + 1) & 31);
    return r;
  endfunction

  task automatic write_base_year(int unsigned v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * REG_BASE_YEAR);
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    base_yr = v & 16'h3FFF;
  endtask

  // Waits for the pipeline to drain so the register may be written.
  task automatic drain();
    while (pending_dates.size() != 0) @(posedge clk_i);
    repeat (LAT + 4) @(posedge clk_i);
  endtask

  task automatic send_date(logic [13:0] y, logic [3:0] m, logic [4:0] d, logic [16:0] off,
                           bit chk, date_res_t want);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    valid_i       <= 1'b1;
    in_year_i     <= y;
    in_month_i    <= m;
    in_day_i      <= d;
    offset_days_i <= off;
    do @(posedge clk_i); while (stall_o);
    pending_dates.push_back(chk ? want : convert_date(y, m, d, off));
    n_sent++;
  endtask

  task automatic send_random();
    int unsigned y, m, d, off;
    if ($urandom_range(0, 9) < 8) begin
      y = base_yr + $urandom_range(0, SPAN - 1);
      m = $urandom_range(1, 12);
      d = $urandom_range(1, days_in_month(m, y));
      case ($urandom_range(0, 3))
        0:       off = $urandom_range(0, 40);
        1:       off = $urandom_range(0, 1000);
        2:       off = $urandom_range(0, 100000);
        default: off = $urandom_range(0, 131071);
      endcase
    end else begin
      y   = $urandom_range(0, 16383);
      m   = $urandom_range(0, 15);
      d   = $urandom_range(0, 31);
      off = $urandom_range(0, 131071);
    end
    send_date(14'(y), 4'(m), 5'(d), 17'(off), 1'b0, '0);
  endtask

  dir_row_t dir_rows[] = '{
    '{1900, 1, 1, 0, 1, '{0, 0, 1900, 1, 1, ST_OK}},
    '{1900, 1, 1, 1, 1, '{0, 0, 1900, 1, 2, ST_OK}},
    '{1900, 1, 7, 0, 1, '{6, 6, 1900, 1, 7, ST_OK}},
    '{1900, 0, 1, 0, 1, '{0, 0, 0, 0, 0, ST_INVALID}},
    '{1900, 13, 1, 0, 1, '{0, 0, 0, 0, 0, ST_INVALID}},
    '{1900, 15, 31, 0, 1, '{0, 0, 0, 0, 0, ST_INVALID}},
    '{1900, 1, 0, 0, 1, '{0, 0, 0, 0, 0, ST_INVALID}},
    '{1900, 4, 31, 0, 1, '{0, 0, 0, 0, 0, ST_INVALID}},
    '{1900, 2, 29, 0, 1, '{0, 0, 0, 0, 0, ST_INVALID}},
    '{1899, 12, 31, 0, 1, '{0, 0, 0, 0, 0, ST_INVALID}},
    '{2156, 1, 1, 0, 1, '{0, 0, 0, 0, 0, ST_INVALID}},
    '{0, 1, 1, 0, 1, '{0, 0, 0, 0, 0, ST_INVALID}},
    '{16383, 12, 31, 131071, 1, '{0, 0, 0, 0, 0, ST_INVALID}},
    '{1900, 1, 1, 131071, 1, '{0, 0, 0, 0, 0, ST_SPAN}},
    '{1900, 1, 31, 0, 0, '0},
    '{1900, 4, 30, 0, 0, '0},
    '{1900, 12, 31, 1, 0, '0},
    '{2000, 2, 29, 0, 0, '0},
    '{1904, 2, 29, 365, 0, '0},
    '{2155, 12, 31, 0, 0, '0},
    '{2155, 12, 31, 1, 0, '0},
    '{2000, 6, 15, 100000, 0, '0},
    '{2100, 2, 28, 1, 0, '0}
  };

  int unsigned phase_bases[5] = '{1900, 1583, 9999, 2000, 0};

  initial begin
    rst_ni = 1'b0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    valid_i = 1'b0; in_year_i = '0; in_month_i = '0; in_day_i = '0; offset_days_i = '0;
    stall_i = 1'b0;
    base_yr = BASE_RESET;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i])
      send_date(dir_rows[i].yr, dir_rows[i].mo, dir_rows[i].dy, dir_rows[i].off,
                dir_rows[i].chk, dir_rows[i].want);
    phase_bases[4] = $urandom_range(1584, 9998);
    for (int p = 0; p < 5; p++) begin
      valid_i <= 1'b0;
      drain();
      write_base_year(phase_bases[p]);
      if (p == 1) long_hold = 1'b1;
      if (p == 4) quiet = 1'b1;
      repeat (200) send_random();
    end
    valid_i <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk_i);
    repeat (LAT + 10) @(posedge clk_i);
    $display("Converted %0d dates (%0d checked) across base years 1900, 1583, 9999, 2000, %0d",
             n_sent, n_checked, phase_bases[4]);
    $display("including invalid dates, span overflows and a long output backpressure.");
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Output-side backpressure, with one long hold so the pipeline fills.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        stall_i <= 1'b1;
        repeat (80) @(posedge clk_i);
        stall_i   <= 1'b0;
        long_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        stall_i <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        stall_i <= 1'b0;
      end
    end
  end

  initial begin
    date_res_t want, got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && valid_o && !stall_i) begin
        got = '{serial_day_o, weekday_o, out_year_o, out_month_o, out_day_o,
                status_e'(status_o)};
        n_checked++;
        if (pending_dates.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected output transaction: %p", got);
        end else begin
          want = pending_dates.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected %p, got %p", want, got);
          end
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> files.f
hdl/cdsc_pkg.sv
hdl/cdsc_front.sv
hdl/cdsc_back.sv
hdl/cdsc_out.sv
hdl/calendar_date_serial_converter_top.sv
dv/tb_calendar_date_serial_converter_top.sv
